// ----- rtl/sha256_message_digest_assert.svh -----
// Assertion macros used by the SHA-256 digest RTL.
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH

// Checks a property on every rising edge of clk, except while rst is high.
`define SHAMD_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property on every rising edge of clk, reset cycles included.
`define SHAMD_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/shamd_pkg.sv -----
// Package with the types, constants and helper function of the SHA-256 digest block.
`timescale 1ns / 1ps

package shamd_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] vars_t;

  // One input transfer: a message byte and its marks.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       is_last;
  } byte_item_t;

  // One output transfer: a digest word and its position.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_MARK,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_ROUND,
    S_FINAL,
    S_OUT
  } state_t;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] LEN_FILL      = 6'd56;
  localparam logic [5:0] LAST_FILL     = 6'd63;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [2:0] LAST_INDEX    = 3'd7;

  localparam vars_t INIT_HASH = '{
    0: 32'h6a09e667, 1: 32'hbb67ae85, 2: 32'h3c6ef372, 3: 32'ha54ff53a,
    4: 32'h510e527f, 5: 32'h9b05688c, 6: 32'h1f83d9ab, 7: 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Rotates a word right by n bits.
  function automatic word_t rotr(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

endpackage

// ----- rtl/shamd_round.sv -----
// One SHA-256 round and one message schedule expansion step.
`timescale 1ns / 1ps

module shamd_round (
  input  shamd_pkg::vars_t vars,
  input  shamd_pkg::word_t w,
  input  shamd_pkg::word_t k,
  input  shamd_pkg::word_t win1,
  input  shamd_pkg::word_t win9,
  input  shamd_pkg::word_t win14,
  output shamd_pkg::vars_t vars_next,
  output shamd_pkg::word_t w_new
);

  shamd_pkg::word_t s1;
  shamd_pkg::word_t ch;
  shamd_pkg::word_t t1;
  shamd_pkg::word_t s0;
  shamd_pkg::word_t maj;
  shamd_pkg::word_t ls0;
  shamd_pkg::word_t ls1;

  // Compression round on the working variables, a in entry 0.
  always_comb begin
    s1  = shamd_pkg::rotr(vars[4], 5'd6) ^ shamd_pkg::rotr(vars[4], 5'd11)
        ^ shamd_pkg::rotr(vars[4], 5'd25);
    ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    t1  = vars[7] + s1 + ch + k + w;
    s0  = shamd_pkg::rotr(vars[0], 5'd2) ^ shamd_pkg::rotr(vars[0], 5'd13)
        ^ shamd_pkg::rotr(vars[0], 5'd22);
    maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    vars_next[7] = vars[6];
    vars_next[6] = vars[5];
    vars_next[5] = vars[4];
    vars_next[4] = vars[3] + t1;
    vars_next[3] = vars[2];
    vars_next[2] = vars[1];
    vars_next[1] = vars[0];
    vars_next[0] = t1 + s0 + maj;
  end

  // Schedule word sixteen places ahead of the one in use this round.
  always_comb begin
    ls0   = shamd_pkg::rotr(win1, 5'd7) ^ shamd_pkg::rotr(win1, 5'd18) ^ (win1 >> 3);
    ls1   = shamd_pkg::rotr(win14, 5'd17) ^ shamd_pkg::rotr(win14, 5'd19) ^ (win14 >> 10);
    w_new = w + ls0 + win9 + ls1;
  end

endmodule

// ----- rtl/sha256_message_digest.sv -----
// Top level of the streaming SHA-256 message digest block.
//
//   channel  dir  handshake                     payload
//   byte     in   byte_valid / byte_stall       byte_item (byte_item_t)
//   digest   out  digest_valid / digest_stall   digest_item (digest_item_t)
//
// A byte that neither completes a block nor ends the message leaves the block idle. The 64th
// byte starts 64 rounds on the single round unit and then adds the result into the hash,
// with byte_stall high throughout, so no new byte is taken meanwhile.
// A last item pads one byte per cycle up to byte 56 (with an extra compression when more
// than 55 bytes were pending), shifts in the 8 length bytes, compresses, then offers the
// eight digest words. Reset loads the initial vector; byte_stall is high unless idle.
`timescale 1ns / 1ps
`include "sha256_message_digest_assert.svh"

module sha256_message_digest (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_stall,
  input  shamd_pkg::byte_item_t     byte_item,
  output logic                      digest_valid,
  input  logic                      digest_stall,
  output shamd_pkg::digest_item_t   digest_item
);

  shamd_pkg::state_t state;
  shamd_pkg::state_t state_next;
  shamd_pkg::state_t ret_state;
  shamd_pkg::state_t ret_state_next;

  logic [5:0]   fill;
  logic [5:0]   rnd;
  logic [60:0]  byte_count;
  logic [2:0]   len_idx;
  logic [2:0]   out_idx;
  logic [511:0] blk;
  shamd_pkg::vars_t hash;
  shamd_pkg::vars_t vars;
  shamd_pkg::vars_t vars_round;
  shamd_pkg::word_t w_new;

  logic        byte_xfer;
  logic        digest_xfer;
  logic        shift_en;
  logic [7:0]  shift_byte;
  logic        start_comp;
  logic [63:0] len_bits;
  logic [63:0] len_sh;

  assign byte_stall  = (state != shamd_pkg::S_IDLE);
  assign byte_xfer   = byte_valid && !byte_stall;
  assign digest_valid = (state == shamd_pkg::S_OUT);
  assign digest_xfer = digest_valid && !digest_stall;

  assign digest_item.digest_word = hash[out_idx];
  assign digest_item.word_index  = out_idx;
  assign digest_item.last_word   = (out_idx == shamd_pkg::LAST_INDEX);

  // Big-endian bit length, taken out one byte at a time, high byte first.
  assign len_bits = {byte_count, 3'b000};
  assign len_sh   = len_bits >> {(shamd_pkg::LAST_INDEX - len_idx), 3'b000};

  // Round unit, fed from the head of the block shift register.
  shamd_round u_round (
    .vars      (vars),
    .w         (blk[511:480]),
    .k         (shamd_pkg::ROUND_K[rnd]),
    .win1      (blk[479:448]),
    .win9      (blk[223:192]),
    .win14     (blk[63:32]),
    .vars_next (vars_round),
    .w_new     (w_new)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shamd_pkg::S_IDLE;
      ret_state <= shamd_pkg::S_IDLE;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
    end
  end

  // Next state, byte shifting and compression start.
  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    shift_en       = 1'b0;
    shift_byte     = '0;
    start_comp     = 1'b0;
    unique case (state)
      shamd_pkg::S_IDLE: begin
        if (byte_xfer) begin
          if (byte_item.byte_present) begin
            shift_en   = 1'b1;
            shift_byte = byte_item.data_byte;
            if (fill == shamd_pkg::LAST_FILL) begin
              start_comp     = 1'b1;
              state_next     = shamd_pkg::S_ROUND;
              ret_state_next = byte_item.is_last ? shamd_pkg::S_PAD_MARK
                                                 : shamd_pkg::S_IDLE;
            end else if (byte_item.is_last) begin
              state_next = shamd_pkg::S_PAD_MARK;
            end
          end else if (byte_item.is_last) begin
            state_next = shamd_pkg::S_PAD_MARK;
          end
        end
      end
      shamd_pkg::S_PAD_MARK: begin
        shift_en   = 1'b1;
        shift_byte = shamd_pkg::PAD_MARK_BYTE;
        if (fill == shamd_pkg::LAST_FILL) begin
          start_comp     = 1'b1;
          state_next     = shamd_pkg::S_ROUND;
          ret_state_next = shamd_pkg::S_PAD_ZERO;
        end else begin
          state_next = shamd_pkg::S_PAD_ZERO;
        end
      end
      shamd_pkg::S_PAD_ZERO: begin
        if (fill == shamd_pkg::LEN_FILL) begin
          state_next = shamd_pkg::S_PAD_LEN;
        end else begin
          shift_en = 1'b1;
          if (fill == shamd_pkg::LAST_FILL) begin
            start_comp     = 1'b1;
            state_next     = shamd_pkg::S_ROUND;
            ret_state_next = shamd_pkg::S_PAD_ZERO;
          end
        end
      end
      shamd_pkg::S_PAD_LEN: begin
        shift_en   = 1'b1;
        shift_byte = len_sh[7:0];
        if (len_idx == shamd_pkg::LAST_INDEX) begin
          start_comp     = 1'b1;
          state_next     = shamd_pkg::S_ROUND;
          ret_state_next = shamd_pkg::S_OUT;
        end
      end
      shamd_pkg::S_ROUND: begin
        if (rnd == shamd_pkg::LAST_ROUND) begin
          state_next = shamd_pkg::S_FINAL;
        end
      end
      shamd_pkg::S_FINAL: begin
        state_next = ret_state;
      end
      shamd_pkg::S_OUT: begin
        if (digest_xfer && (out_idx == shamd_pkg::LAST_INDEX)) begin
          state_next = shamd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = shamd_pkg::S_IDLE;
      end
    endcase
  end

  // Counters and hash state.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      rnd        <= '0;
      byte_count <= '0;
      len_idx    <= '0;
      out_idx    <= '0;
      hash       <= shamd_pkg::INIT_HASH;
    end else begin
      if (shift_en) begin
        fill <= fill + 6'd1;
      end
      if (byte_xfer && byte_item.byte_present) begin
        byte_count <= byte_count + 61'd1;
      end
      if (state == shamd_pkg::S_PAD_LEN) begin
        len_idx <= len_idx + 3'd1;
      end
      if (start_comp) begin
        rnd <= '0;
      end else if (state == shamd_pkg::S_ROUND) begin
        rnd <= rnd + 6'd1;
      end
      if (state == shamd_pkg::S_FINAL) begin
        for (int j = 0; j < 8; j++) begin
          hash[j] <= hash[j] + vars[j];
        end
      end
      if (digest_xfer) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == shamd_pkg::LAST_INDEX) begin
          hash       <= shamd_pkg::INIT_HASH;
          byte_count <= '0;
        end
      end
    end
  end

  // Block shift register, reused as the schedule window, and the working variables.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      blk <= {blk[503:0], shift_byte};
    end else if (state == shamd_pkg::S_ROUND) begin
      blk <= {blk[479:0], w_new};
    end
    if (start_comp) begin
      vars <= hash;
    end else if (state == shamd_pkg::S_ROUND) begin
      vars <= vars_round;
    end
  end

  // Consistency checks on the sequencer.
  `SHAMD_CHECK(a_round_starts_at_zero, (state == shamd_pkg::S_ROUND && $past(state) != shamd_pkg::S_ROUND) |-> (rnd == '0), "compression did not start at round zero")
  `SHAMD_CHECK(a_len_after_zero_fill, (state == shamd_pkg::S_PAD_LEN) |-> (fill >= shamd_pkg::LEN_FILL), "length bytes entered before byte 56")
  `SHAMD_CHECK(a_hash_reinit, (digest_xfer && out_idx == shamd_pkg::LAST_INDEX) |=> (hash[0] == shamd_pkg::INIT_HASH[0] && byte_count == '0 && fill == '0), "state not cleared after digest")
  `SHAMD_CHECK_ALWAYS(a_no_shift_in_round, !(shift_en && state == shamd_pkg::S_ROUND), "byte shifted during a round")

endmodule

// ----- tb/sha256_message_digest_tb.sv -----
// Self-checking testbench for the streaming SHA-256 message digest block.
`timescale 1ns / 1ps

module sha256_message_digest_tb;

  localparam int DIGEST_WORDS   = 8;
  localparam int RANDOM_ITEMS   = 262;
  localparam int IDLE_PERCENT   = 31;
  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 200;
  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam int BOUNDARY_LENGTHS [7] = '{54, 55, 56, 57, 63, 64, 65};

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam shamd_pkg::word_t START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam shamd_pkg::word_t ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef shamd_pkg::word_t hash_words_t [8];

  // One row of the directed stimulus; a known digest is typed in where it is common knowledge.
  typedef struct {
    shamd_pkg::byte_item_t item;
    bit                    known;
    logic [255:0]          digest;
  } directed_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    byte_valid = 1'b0;
  logic                    byte_stall;
  shamd_pkg::byte_item_t   byte_item = '0;
  logic                    digest_valid;
  logic                    digest_stall = 1'b0;
  shamd_pkg::digest_item_t digest_item;

  // Predictor state: chaining value, partial block and message length.
  hash_words_t  hash_chain;
  logic [7:0]   block_bytes [64];
  int           block_fill_count;
  logic [60:0]  message_length;

  shamd_pkg::digest_item_t pending_digest_words [$];
  directed_row_t           directed_rows [$];

  bit no_idle = 1'b0;
  int error_count = 0;
  int messages_done = 0;
  int bytes_hashed = 0;
  int words_checked = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  sha256_message_digest dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_item  (digest_item)
  );

  function automatic shamd_pkg::word_t rot_right(input shamd_pkg::word_t x,
                                                 input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic directed_row_t make_row(input logic [7:0] data, input bit present,
                                             input bit last, input bit known = 1'b0,
                                             input logic [255:0] digest = '0);
    directed_row_t row;
    row.item.data_byte    = data;
    row.item.byte_present = present;
    row.item.is_last      = last;
    row.known             = known;
    row.digest            = digest;
    return row;
  endfunction

  // Appends one row to the directed table.
  task automatic queue_row(input directed_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic restart_message();
    hash_chain       = START_HASH;
    block_fill_count = 0;
    message_length   = '0;
  endtask

  // Runs the 64 SHA-256 rounds over the buffered block and folds them into the chain.
  task automatic compress_block();
    shamd_pkg::word_t sched [16];
    shamd_pkg::word_t va, vb, vc, vd, ve, vf, vg, vh;
    shamd_pkg::word_t w_now, w15, w2, temp1, temp2;
    for (int j = 0; j < 16; j++) begin
      sched[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2], block_bytes[4*j+3]};
    end
    va = hash_chain[0]; vb = hash_chain[1]; vc = hash_chain[2]; vd = hash_chain[3];
    ve = hash_chain[4]; vf = hash_chain[5]; vg = hash_chain[6]; vh = hash_chain[7];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        w_now = sched[r];
      end else begin
        w15   = sched[(r - 15) & 15];
        w2    = sched[(r - 2) & 15];
        w_now = sched[r & 15] + (rot_right(w15, 7) ^ rot_right(w15, 18) ^ (w15 >> 3))
              + sched[(r - 7) & 15] + (rot_right(w2, 17) ^ rot_right(w2, 19) ^ (w2 >> 10));
        sched[r & 15] = w_now;
      end
      temp1 = vh + (rot_right(ve, 6) ^ rot_right(ve, 11) ^ rot_right(ve, 25))
            + ((ve & vf) ^ (~ve & vg)) + ROUND_CONST[r] + w_now;
      temp2 = (rot_right(va, 2) ^ rot_right(va, 13) ^ rot_right(va, 22))
            + ((va & vb) ^ (va & vc) ^ (vb & vc));
      vh = vg; vg = vf; vf = ve; ve = vd + temp1;
      vd = vc; vc = vb; vb = va; va = temp1 + temp2;
    end
    hash_chain[0] += va; hash_chain[1] += vb; hash_chain[2] += vc; hash_chain[3] += vd;
    hash_chain[4] += ve; hash_chain[5] += vf; hash_chain[6] += vg; hash_chain[7] += vh;
  endtask

  // Advances the predictor by one transfer; a last mark pads, finishes and yields the digest.
  task automatic hash_item(input shamd_pkg::byte_item_t it, output bit finished,
                           output hash_words_t words);
    logic [63:0] bit_length;
    if (it.byte_present) begin
      block_bytes[block_fill_count] = it.data_byte;
      block_fill_count++;
      message_length++;
      if (block_fill_count == 64) begin
        compress_block();
        block_fill_count = 0;
      end
    end
    finished = it.is_last;
    words    = hash_chain;
    if (it.is_last) begin
      bit_length = {message_length, 3'b000};
      block_bytes[block_fill_count] = PAD_MARKER;
      block_fill_count++;
      // No room for the length field: close this block and pad a fresh one.
      if (block_fill_count > 56) begin
        for (int j = block_fill_count; j < 64; j++) block_bytes[j] = 8'h00;
        compress_block();
        block_fill_count = 0;
      end
      for (int j = block_fill_count; j < 56; j++) block_bytes[j] = 8'h00;
      for (int j = 0; j < 8; j++) block_bytes[63 - j] = bit_length[8*j +: 8];
      compress_block();
      words = hash_chain;
      restart_message();
    end
  endtask

  // Offers one item to the block, possibly after random idle cycles, and records it once accepted.
  task automatic send_item(input shamd_pkg::byte_item_t it, input bit known = 1'b0,
                           input logic [255:0] known_digest = '0);
    bit                      finished;
    hash_words_t             words;
    shamd_pkg::digest_item_t expected;
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    hash_item(it, finished, words);
    if (it.byte_present) bytes_hashed++;
    if (finished) begin
      messages_done++;
      for (int j = 0; j < DIGEST_WORDS; j++) begin
        expected.digest_word = known ? known_digest[255 - 32*j -: 32] : words[j];
        expected.word_index  = 3'(j);
        expected.last_word   = (j == DIGEST_WORDS - 1);
        pending_digest_words.insert(pending_digest_words.size(), expected);
      end
    end
  endtask

  // Holds the byte channel quiet until every outstanding digest word has come back.
  task automatic wait_for_digests();
    byte_valid <= 1'b0;
    while (pending_digest_words.size() != 0) @(posedge clk);
  endtask

  // Digest side: random stall and a field-by-field check of every word transfer.
  always @(posedge clk) begin
    shamd_pkg::digest_item_t expected;
    if (!rst) begin
      if (digest_valid && !digest_stall) begin
        if (pending_digest_words.size() == 0) begin
          note_error($sformatf("unexpected digest word %h index %0d last %0b",
                               digest_item.digest_word, digest_item.word_index,
                               digest_item.last_word));
        end else begin
          expected = pending_digest_words.pop_front();
          words_checked++;
          if (digest_item.digest_word !== expected.digest_word ||
              digest_item.word_index !== expected.word_index ||
              digest_item.last_word !== expected.last_word) begin
            note_error($sformatf("expected word %h index %0d last %0b, got %h index %0d last %0b",
                                 expected.digest_word, expected.word_index, expected.last_word,
                                 digest_item.digest_word, digest_item.word_index,
                                 digest_item.last_word));
          end
        end
      end
      digest_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Watchdog on cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (digest_valid && !digest_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transfer", WATCHDOG_LIMIT);
      $display("** sha256_message_digest: FAILED **");
      $finish;
    end
  end

  // Stimulus: directed table, then random messages of varied lengths.
  initial begin
    shamd_pkg::byte_item_t it;
    int                    items_sent;
    int                    msg_count;
    int                    msg_len;
    bit                    end_with_byte;
    restart_message();
    for (int j = 0; j < 64; j++) block_bytes[j] = 8'h00;

    // Empty message, the classic three-byte message, byte extremes and ignored items.
    queue_row(make_row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST));
    queue_row(make_row(8'h61, 1'b1, 1'b0));
    queue_row(make_row(8'h62, 1'b1, 1'b0));
    queue_row(make_row(8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST));
    queue_row(make_row(8'h00, 1'b1, 1'b0));
    queue_row(make_row(8'hff, 1'b1, 1'b0));
    queue_row(make_row(8'ha5, 1'b0, 1'b0));
    queue_row(make_row(8'h5a, 1'b0, 1'b1));
    queue_row(make_row(8'hff, 1'b1, 1'b1));
    queue_row(make_row(8'hff, 1'b0, 1'b1));
    queue_row(make_row(8'h80, 1'b1, 1'b0));
    queue_row(make_row(8'hff, 1'b0, 1'b0));
    queue_row(make_row(8'h7f, 1'b1, 1'b0));
    queue_row(make_row(8'h01, 1'b1, 1'b1));
    queue_row(make_row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].digest);
    end
    wait_for_digests();

    // Random messages: many short, many at the padding and block boundaries.
    items_sent = 0;
    msg_count  = 0;
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = (msg_count >= 1 && msg_count < 3);
      case ($urandom_range(9))
        0, 1, 2, 3: msg_len = $urandom_range(0, 12);
        4, 5, 6:    msg_len = BOUNDARY_LENGTHS[$urandom_range(0, 6)];
        7:          msg_len = $urandom_range(118, 121);
        default:    msg_len = $urandom_range(13, 130);
      endcase
      // The last message is cut to what is left of the item budget.
      if (msg_len > RANDOM_ITEMS - items_sent) msg_len = RANDOM_ITEMS - items_sent;
      end_with_byte = (msg_len > 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < msg_len; i++) begin
        // Ignored items sprinkled between message bytes.
        if ($urandom_range(9) == 0) begin
          it.data_byte    = 8'($urandom_range(255));
          it.byte_present = 1'b0;
          it.is_last      = 1'b0;
          send_item(it);
          items_sent++;
        end
        it.data_byte    = 8'($urandom_range(255));
        it.byte_present = 1'b1;
        it.is_last      = end_with_byte && (i == msg_len - 1);
        send_item(it);
        items_sent++;
      end
      if (!end_with_byte) begin
        it.data_byte    = 8'($urandom_range(255));
        it.byte_present = 1'b0;
        it.is_last      = 1'b1;
        send_item(it);
        items_sent++;
      end
      if ($urandom_range(4) == 0) begin
        wait_for_digests();
      end
      msg_count++;
    end
    no_idle = 1'b0;

    wait_for_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_digest_words.size() != 0) begin
      note_error($sformatf("%0d digest words never arrived", pending_digest_words.size()));
    end

    $display("Hashed %0d messages (%0d message bytes) and checked %0d digest words,",
             messages_done, bytes_hashed, words_checked);
    $display("including empty, one-byte and block-boundary lengths; %0d errors.", error_count);
    if (error_count == 0) begin
      $display("** sha256_message_digest: PASSED **");
    end else begin
      $display("** sha256_message_digest: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/shamd_pkg.sv
rtl/shamd_round.sv
rtl/sha256_message_digest.sv
tb/sha256_message_digest_tb.sv
